[sv/fdgbo_pkg.sv]
// ----------------------------------------------------------------------------
// Frame downscale, gray sample and box overlay: shared definitions
// Frame geometry, field widths, divider constants and the job format that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package fdgbo_pkg;

  localparam int FRAME_W = 160;
  localparam int FRAME_H = 120;
  localparam int MODEL_W = 50;
  localparam int MODEL_H = 50;

  localparam int PIX_DEPTH = FRAME_W * FRAME_H;
  localparam int ADDR_W    = $clog2(PIX_DEPTH);
  localparam int COL_W     = $clog2(FRAME_W);
  localparam int ROW_W     = $clog2(FRAME_H);
  localparam int CNT_W     = (COL_W > ROW_W) ? COL_W : ROW_W;

  localparam int CMD_W  = 2;
  localparam int PIDX_W = 15;
  localparam int PIX_W  = 16;
  localparam int BOXC_W = 6;
  localparam int SIDX_W = 12;
  localparam int GRAY_W = 16;

  localparam logic [PIX_W-1:0] BOX_COLOR_RST = 16'hF800;

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  // Widths of every dividend that is divided by a model dimension.
  localparam int MY_MAX   = ((1 << SIDX_W) - 1) / MODEL_W;
  localparam int BSUM_MAX = 2 * ((1 << BOXC_W) - 1);
  localparam int DIV_A_W  = SIDX_W;
  localparam int DIV_B_W  = $clog2(MODEL_W * FRAME_W);
  localparam int DIV_C_W  = $clog2((MY_MAX + 1) * FRAME_H);
  localparam int DIV_D_W  = $clog2(BSUM_MAX * FRAME_W + 1);
  localparam int DIV_E_W  = $clog2(BSUM_MAX * FRAME_H + 1);
  localparam int DV_W     = max2(max2(max2(DIV_A_W, DIV_B_W), max2(DIV_C_W, DIV_D_W)),
                                 DIV_E_W);

  // Truncated reciprocals; the quotient estimate is low by at most one.
  localparam int RCP_MW = (1 << DV_W) / MODEL_W;
  localparam int RCP_MH = (1 << DV_W) / MODEL_H;

  localparam int QUEUE_D = 4;
  localparam int QPTR_W  = $clog2(QUEUE_D);
  localparam int QCNT_W  = $clog2(QUEUE_D + 1);

  typedef logic [DV_W-1:0]   dv_t;
  typedef logic [2*DV_W-1:0] dvp_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_BOX   = 2'd1,
    CMD_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  data;
    logic [ADDR_W-1:0] row1_addr;
    logic [ADDR_W-1:0] col1_addr;
    logic [COL_W-1:0]  len_w;
    logic [ROW_W-1:0]  len_h;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

[sv/fdgbo_in_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one command transaction into the block.
// ----------------------------------------------------------------------------
interface fdgbo_in_if import fdgbo_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [PIDX_W-1:0] pixel_index;
  logic [PIX_W-1:0]  pixel_value;
  logic [BOXC_W-1:0] box_x;
  logic [BOXC_W-1:0] box_y;
  logic [BOXC_W-1:0] box_w;
  logic [BOXC_W-1:0] box_h;
  logic [SIDX_W-1:0] sample_index;

  modport source (
    output valid, command, pixel_index, pixel_value, box_x, box_y, box_w, box_h,
           sample_index,
    input  ready
  );

  modport sink (
    input  valid, command, pixel_index, pixel_value, box_x, box_y, box_w, box_h,
           sample_index,
    output ready
  );

endinterface

[sv/fdgbo_out_if.sv]
// ----------------------------------------------------------------------------
// Gray result channel
// Valid/ready channel that carries one gray sample transaction out.
// ----------------------------------------------------------------------------
interface fdgbo_out_if import fdgbo_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [GRAY_W-1:0] gray_value;

  modport source (
    output valid, gray_value,
    input  ready
  );

  modport sink (
    input  valid, gray_value,
    output ready
  );

endinterface

[sv/fdgbo_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdgbo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/fdgbo_front.sv]
// ----------------------------------------------------------------------------
// Command front end
// Accepts command transactions, drops the ones without effect, and maps box
// corners and sample positions to frame addresses in an eight-stage pipeline.
// ----------------------------------------------------------------------------
module fdgbo_front import fdgbo_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fdgbo_in_if.sink   in_ch,
  output logic       q_push,
  output job_t       q_job,
  input  logic       q_full
);

  localparam int NSTG  = 8;
  localparam int NLANE = 4;
  localparam dv_t LANE_DIV [NLANE] = '{dv_t'(MODEL_W), dv_t'(MODEL_W),
                                       dv_t'(MODEL_H), dv_t'(MODEL_H)};
  localparam dv_t LANE_RCP [NLANE] = '{dv_t'(RCP_MW), dv_t'(RCP_MW),
                                       dv_t'(RCP_MH), dv_t'(RCP_MH)};

  function automatic dvp_t rcp_mul(dv_t x, dv_t rcp);
    return dvp_t'(x) * dvp_t'(rcp);
  endfunction

  function automatic dv_t lane_q(dv_t est, dv_t rem, dv_t dvs);
    return (rem >= dvs) ? est + 1'b1 : est;
  endfunction

  function automatic logic [COL_W-1:0] sat_col(dv_t q);
    return (q >= dv_t'(FRAME_W)) ? COL_W'(FRAME_W - 1) : q[COL_W-1:0];
  endfunction

  function automatic logic [ROW_W-1:0] sat_row(dv_t q);
    return (q >= dv_t'(FRAME_H)) ? ROW_W'(FRAME_H - 1) : q[ROW_W-1:0];
  endfunction

  logic [NSTG-1:0]   vld_r;
  logic              adv;
  logic              keep;

  op_t               op_r   [1:NSTG-1];
  logic [ADDR_W-1:0] wa_r   [1:NSTG-1];
  logic [PIX_W-1:0]  wd_r   [1:NSTG-1];

  dv_t               sidx1_r;
  dvp_t              pa1_r;
  dv_t               bx1_r  [NLANE];
  dv_t               qa2_r;
  dv_t               ra2_r;
  dvp_t              bp2_r  [NLANE];
  dv_t               bx2_r  [NLANE];
  dv_t               mx3_r;
  dv_t               my3_r;
  dv_t               est3_r [NLANE];
  dv_t               rm3_r  [NLANE];
  dv_t               xb4_r;
  dv_t               yc4_r;
  logic [COL_W-1:0]  fx0_4_r, fx1_4_r;
  logic [ROW_W-1:0]  fy0_4_r, fy1_4_r;
  dvp_t              pb5_r, pc5_r;
  dv_t               xb5_r, yc5_r;
  logic [ADDR_W-1:0] r0w5_r, r1w5_r;
  logic [COL_W-1:0]  fx0_5_r, fx1_5_r;
  logic [COL_W-1:0]  lw5_r, lw6_r, lw7_r;
  logic [ROW_W-1:0]  lh5_r, lh6_r, lh7_r;
  dv_t               eb6_r, rb6_r, ec6_r, rc6_r;
  logic [ADDR_W-1:0] a00_6_r, a10_6_r, a01_6_r;
  logic [ADDR_W-1:0] a00_7_r, a10_7_r, a01_7_r;
  logic [COL_W-1:0]  sx7_r;
  logic [ROW_W-1:0]  sy7_r;
  job_t              job8_r;

  assign adv         = !(vld_r[NSTG-1] && q_full);
  assign in_ch.ready = adv;
  assign q_push      = vld_r[NSTG-1] && !q_full;
  assign q_job       = job8_r;

  always_comb begin
    keep = 1'b0;
    if (in_ch.valid) begin
      unique case (in_ch.command)
        CMD_WRITE: keep = (32'(in_ch.pixel_index) < 32'(PIX_DEPTH));
        CMD_BOX:   keep = 1'b1;
        CMD_READ:  keep = 1'b1;
        default:   keep = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], keep};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op_r[1]  <= op_t'(in_ch.command);
      wa_r[1]  <= ADDR_W'(in_ch.pixel_index);
      wd_r[1]  <= in_ch.pixel_value;
      for (int s = 2; s < NSTG; s++) begin
        op_r[s] <= op_r[s-1];
        wa_r[s] <= wa_r[s-1];
        wd_r[s] <= wd_r[s-1];
      end

      sidx1_r  <= dv_t'(in_ch.sample_index);
      pa1_r    <= rcp_mul(dv_t'(in_ch.sample_index), dv_t'(RCP_MW));
      bx1_r[0] <= dv_t'(in_ch.box_x) * dv_t'(FRAME_W);
      bx1_r[1] <= (dv_t'(in_ch.box_x) + dv_t'(in_ch.box_w)) * dv_t'(FRAME_W);
      bx1_r[2] <= dv_t'(in_ch.box_y) * dv_t'(FRAME_H);
      bx1_r[3] <= (dv_t'(in_ch.box_y) + dv_t'(in_ch.box_h)) * dv_t'(FRAME_H);

      qa2_r <= pa1_r[2*DV_W-1:DV_W];
      ra2_r <= sidx1_r - pa1_r[2*DV_W-1:DV_W] * dv_t'(MODEL_W);
      for (int i = 0; i < NLANE; i++) begin
        bp2_r[i] <= rcp_mul(bx1_r[i], LANE_RCP[i]);
        bx2_r[i] <= bx1_r[i];
      end

      if (ra2_r >= dv_t'(MODEL_W)) begin
        my3_r <= qa2_r + 1'b1;
        mx3_r <= ra2_r - dv_t'(MODEL_W);
      end else begin
        my3_r <= qa2_r;
        mx3_r <= ra2_r;
      end
      for (int i = 0; i < NLANE; i++) begin
        est3_r[i] <= bp2_r[i][2*DV_W-1:DV_W];
        rm3_r[i]  <= bx2_r[i] - bp2_r[i][2*DV_W-1:DV_W] * LANE_DIV[i];
      end

      xb4_r   <= mx3_r * dv_t'(FRAME_W);
      yc4_r   <= my3_r * dv_t'(FRAME_H);
      fx0_4_r <= sat_col(lane_q(est3_r[0], rm3_r[0], LANE_DIV[0]));
      fx1_4_r <= sat_col(lane_q(est3_r[1], rm3_r[1], LANE_DIV[1]));
      fy0_4_r <= sat_row(lane_q(est3_r[2], rm3_r[2], LANE_DIV[2]));
      fy1_4_r <= sat_row(lane_q(est3_r[3], rm3_r[3], LANE_DIV[3]));

      pb5_r   <= rcp_mul(xb4_r, dv_t'(RCP_MW));
      pc5_r   <= rcp_mul(yc4_r, dv_t'(RCP_MH));
      xb5_r   <= xb4_r;
      yc5_r   <= yc4_r;
      r0w5_r  <= ADDR_W'(fy0_4_r) * ADDR_W'(FRAME_W);
      r1w5_r  <= ADDR_W'(fy1_4_r) * ADDR_W'(FRAME_W);
      fx0_5_r <= fx0_4_r;
      fx1_5_r <= fx1_4_r;
      lw5_r   <= fx1_4_r - fx0_4_r;
      lh5_r   <= fy1_4_r - fy0_4_r;

      eb6_r   <= pb5_r[2*DV_W-1:DV_W];
      rb6_r   <= xb5_r - pb5_r[2*DV_W-1:DV_W] * dv_t'(MODEL_W);
      ec6_r   <= pc5_r[2*DV_W-1:DV_W];
      rc6_r   <= yc5_r - pc5_r[2*DV_W-1:DV_W] * dv_t'(MODEL_H);
      a00_6_r <= r0w5_r + ADDR_W'(fx0_5_r);
      a10_6_r <= r1w5_r + ADDR_W'(fx0_5_r);
      a01_6_r <= r0w5_r + ADDR_W'(fx1_5_r);
      lw6_r   <= lw5_r;
      lh6_r   <= lh5_r;

      sx7_r   <= sat_col(lane_q(eb6_r, rb6_r, dv_t'(MODEL_W)));
      sy7_r   <= sat_row(lane_q(ec6_r, rc6_r, dv_t'(MODEL_H)));
      a00_7_r <= a00_6_r;
      a10_7_r <= a10_6_r;
      a01_7_r <= a01_6_r;
      lw7_r   <= lw6_r;
      lh7_r   <= lh6_r;

      job8_r.op        <= op_r[NSTG-1];
      job8_r.data      <= wd_r[NSTG-1];
      job8_r.row1_addr <= a10_7_r;
      job8_r.col1_addr <= a01_7_r;
      job8_r.len_w     <= lw7_r;
      job8_r.len_h     <= lh7_r;
      if (op_r[NSTG-1] == CMD_READ) begin
        job8_r.addr <= ADDR_W'(sy7_r) * ADDR_W'(FRAME_W) + ADDR_W'(sx7_r);
      end else if (op_r[NSTG-1] == CMD_BOX) begin
        job8_r.addr <= a00_7_r;
      end else begin
        job8_r.addr <= wa_r[NSTG-1];
      end
    end
  end

endmodule

[sv/fdgbo_queue.sv]
// ----------------------------------------------------------------------------
// Job queue
// Short register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fdgbo_queue import fdgbo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic head_valid,
  output job_t head_job,
  input  logic pop
);

  job_t              ent_r [QUEUE_D];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_D - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (cnt_r == QCNT_W'(QUEUE_D));
  assign head_valid = (cnt_r != '0);
  assign head_job   = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("job queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid) else $error("job queue read while empty");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_D)) else $error("job queue count out of range");
`endif

endmodule

[sv/fdgbo_back.sv]
// ----------------------------------------------------------------------------
// Command back end
// Executes jobs on the frame store: pixel writes, box outline painting and
// gray sample reads, with a registered result stage.
// ----------------------------------------------------------------------------
module fdgbo_back import fdgbo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  job_t             q_job,
  output logic             q_pop,
  output mem_req_t         mem_req,
  input  logic [PIX_W-1:0] mem_rdata,
  fdgbo_out_if.source      out_ch,
  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data
);

  localparam int GRAY_WT_R = 77;
  localparam int GRAY_WT_G = 150;
  localparam int GRAY_WT_B = 29;

  typedef enum logic [4:0] {
    BS_IDLE = 5'b00001,
    BS_ROW0 = 5'b00010,
    BS_ROW1 = 5'b00100,
    BS_COL0 = 5'b01000,
    BS_COL1 = 5'b10000
  } bst_t;

  function automatic logic [GRAY_W-1:0] rgb565_gray(logic [PIX_W-1:0] p);
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    r8 = {p[15:11], 3'b000};
    g8 = {p[10:5], 2'b00};
    b8 = {p[4:0], 3'b000};
    return GRAY_W'(32'(GRAY_WT_R) * 32'(r8) + 32'(GRAY_WT_G) * 32'(g8)
                   + 32'(GRAY_WT_B) * 32'(b8));
  endfunction

  bst_t              state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  job_t              box_r;
  logic              box_load;
  logic [PIX_W-1:0]  color_r;
  logic              rd_pend_r;
  logic              out_valid_r;
  logic [GRAY_W-1:0] out_gray_r;
  logic              out_free;
  logic              take;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.gray_value = out_gray_r;
  assign out_free          = !out_valid_r || out_ch.ready;
  assign take = q_valid && (q_job.op != CMD_READ || (!rd_pend_r && out_free));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    addr_nxt      = addr_r;
    box_load      = 1'b0;
    q_pop         = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = addr_r;
    mem_req.wdata = color_r;
    mem_req.re    = 1'b0;
    mem_req.raddr = q_job.addr;
    unique case (state_r)
      BS_IDLE: begin
        if (take) begin
          q_pop = 1'b1;
          unique case (q_job.op)
            CMD_WRITE: begin
              mem_req.we    = 1'b1;
              mem_req.waddr = q_job.addr;
              mem_req.wdata = q_job.data;
            end
            CMD_READ: begin
              mem_req.re = 1'b1;
            end
            CMD_BOX: begin
              state_nxt = BS_ROW0;
              addr_nxt  = q_job.addr;
              cnt_nxt   = '0;
              box_load  = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      BS_ROW0, BS_ROW1: begin
        mem_req.we = 1'b1;
        if (cnt_r == CNT_W'(box_r.len_w)) begin
          cnt_nxt = '0;
          if (state_r == BS_ROW0) begin
            state_nxt = BS_ROW1;
            addr_nxt  = box_r.row1_addr;
          end else begin
            state_nxt = BS_COL0;
            addr_nxt  = box_r.addr;
          end
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_r + 1'b1;
        end
      end
      BS_COL0, BS_COL1: begin
        mem_req.we = 1'b1;
        if (cnt_r == CNT_W'(box_r.len_h)) begin
          cnt_nxt = '0;
          if (state_r == BS_COL0) begin
            state_nxt = BS_COL1;
            addr_nxt  = box_r.col1_addr;
          end else begin
            state_nxt = BS_IDLE;
          end
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          addr_nxt = addr_r + ADDR_W'(FRAME_W);
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      color_r     <= BOX_COLOR_RST;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rd_pend_r <= mem_req.re;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        color_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    if (box_load) begin
      box_r <= q_job;
    end
    if (rd_pend_r) begin
      out_gray_r <= rgb565_gray(mem_rdata);
    end
  end

`ifndef ASSERT_OFF
  a_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> !out_valid_r) else $error("read data lands on a held result");
  a_box_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BS_IDLE) |-> (!mem_req.re && !q_pop))
    else $error("job taken while painting a box");
  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.re |-> !mem_req.we) else $error("read and write issued together");
`endif

endmodule

[sv/frame_downscale_gray_box_overlay_unit.sv]
// ----------------------------------------------------------------------------
// Frame downscale, gray sample and box overlay unit
// Holds one RGB565 frame and serves pixel write, box outline and gray sample
// commands on a valid/ready channel.
// ----------------------------------------------------------------------------
// A command passes an eight-stage front end and a four-entry job queue before
// the back end executes it on a single frame store with one write and one
// read port. A pixel write is one write to the frame store. A gray sample
// passes the registered read of the frame store and then the result register.
// A box outline paints its two rows and then its two columns, one painted
// pixel per cycle through the write port. The frame store is not cleared
// after reset, so a pixel must be written before it is sampled.
module frame_downscale_gray_box_overlay_unit import fdgbo_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  fdgbo_in_if.sink         in_ch,
  fdgbo_out_if.source      out_ch,
  input  logic             cfg_wr_en,
  input  logic [PIX_W-1:0] cfg_wr_data
);

  logic             q_push;
  job_t             q_push_job;
  logic             q_full;
  logic             q_valid;
  job_t             q_head_job;
  logic             q_pop;
  mem_req_t         mem_req;
  logic [PIX_W-1:0] mem_rdata;

  fdgbo_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_job  (q_push_job),
    .q_full (q_full)
  );

  fdgbo_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .head_valid (q_valid),
    .head_job   (q_head_job),
    .pop        (q_pop)
  );

  fdgbo_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_job       (q_head_job),
    .q_pop       (q_pop),
    .mem_req     (mem_req),
    .mem_rdata   (mem_rdata),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  fdgbo_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

endmodule
